// ===== design/plpc_pkg.sv =====
// Package for the per-peer packet loss counter.
// Types, codes and constants shared by the table, the update logic and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plpc_pkg;

  localparam int PEERS_DEFAULT = 16;
  localparam logic [7:0] TRAILER_BYTES = 8'd2;

  typedef enum logic [1:0] {
    FN_PACKET = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_READ   = 2'd2,
    FN_STOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_OFF      = 3'd1,
    ST_BAD_PEER = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_READ     = 3'd4,
    ST_STOPPED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD
  } ctrl_state_t;

  // One table entry.
  typedef struct packed {
    logic        seen;
    logic [31:0] last_seq;
    logic [31:0] rx_cnt;
    logic [31:0] lost_cnt;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/plpc_table.sv =====
// Peer table: one synchronous memory, one write and one read port, registered read.
// Depends on plpc_pkg (entry_t).
`timescale 1ns / 1ps
`default_nettype none

module plpc_table #(
  parameter int DEPTH = plpc_pkg::PEERS_DEFAULT,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire plpc_pkg::entry_t wdata,
  input  wire logic [AW-1:0]    raddr,
  output plpc_pkg::entry_t      rdata
);
  import plpc_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/plpc_update.sv =====
// Entry update for an accepted packet: count it, add any sequence gap to lost.
// Depends on plpc_pkg (entry_t).
`timescale 1ns / 1ps
`default_nettype none

module plpc_update (
  input  wire plpc_pkg::entry_t cur,
  input  wire logic [31:0]      seq,
  output plpc_pkg::entry_t      nxt
);
  import plpc_pkg::*;

  logic [31:0] expected;
  logic [31:0] gap;

  assign expected = cur.last_seq + 32'd1;
  // gap is zero when the sequence follows on, so no compare is needed
  assign gap      = seq - expected;

  always_comb begin
    nxt          = cur;
    nxt.seen     = 1'b1;
    nxt.last_seq = seq;
    nxt.rx_cnt   = cur.rx_cnt + 32'd1;
    nxt.lost_cnt = cur.seen ? (cur.lost_cnt + gap) : cur.lost_cnt;
  end

endmodule

`default_nettype wire

// ===== design/per_peer_packet_loss_counter.sv =====
// Per-peer packet loss counter, top level. Depends on plpc_pkg, plpc_table, plpc_update.
// Packet and read: table read in the accept cycle; a packet's entry is updated and written back in the next;
//   result strobe registered in S_RD; busy is high in S_RD, so no new transaction is taken there.
// Stop and rejected items: result strobe in the cycle after acceptance, busy stays low.
// Clear: sweeps the table, one entry a cycle; result strobe registered at the end of the sweep.
// Reset: the same sweep (busy high, no result); the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module per_peer_packet_loss_counter #(
  parameter int MAX_PEERS = plpc_pkg::PEERS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_peer_id,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [7:0]  in_frame_length,
  input  wire logic [7:0]  in_signal_byte,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_peer_out,
  output logic [7:0]       out_payload_length,
  output logic [31:0]      out_last_seq,
  output logic [7:0]       out_rssi,
  output logic [31:0]      out_received_count,
  output logic [31:0]      out_lost_count,
  output logic             out_peer_seen
);
  import plpc_pkg::*;

  localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_PEERS - 1);

  ctrl_state_t state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_report_r, clr_report_nxt;
  logic          rx_on_r, rx_on_nxt;

  func_t       pend_func_r, pend_func_nxt;
  logic [15:0] pend_peer_r, pend_peer_nxt;
  logic [31:0] pend_seq_r, pend_seq_nxt;
  logic [7:0]  pend_plen_r, pend_plen_nxt;
  logic [7:0]  pend_rssi_r, pend_rssi_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [15:0] peer_r, peer_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [31:0] lseq_r, lseq_nxt;
  logic [7:0]  rssi_r, rssi_nxt;
  logic [31:0] rx_r, rx_nxt;
  logic [31:0] lost_r, lost_nxt;
  logic        seen_r, seen_nxt;

  logic          accept;
  func_t         func_in;
  logic          peer_ok;
  logic [7:0]    plen_in;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  entry_t        upd_entry;
  entry_t        view;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign func_in = func_t'(in_func);
  assign peer_ok = {1'b0, in_peer_id} < 17'(MAX_PEERS);
  assign plen_in = (in_frame_length >= TRAILER_BYTES) ? (in_frame_length - TRAILER_BYTES)
                                                      : 8'd0;

  plpc_table #(
    .DEPTH (MAX_PEERS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_peer_id[AW-1:0]),
    .rdata (mem_rdata)
  );

  plpc_update u_update (
    .cur (mem_rdata),
    .seq (pend_seq_r),
    .nxt (upd_entry)
  );

  // what a result shows of an entry: a packet shows the updated entry; last_seq reads zero if not seen
  always_comb begin
    view = (pend_func_r == FN_PACKET) ? upd_entry : mem_rdata;
    if (!view.seen) begin
      view.last_seq = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      clr_report_r <= 1'b0;
      rx_on_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_report_r <= clr_report_nxt;
      rx_on_r      <= rx_on_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_func_r <= pend_func_nxt;
    pend_peer_r <= pend_peer_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_plen_r <= pend_plen_nxt;
    pend_rssi_r <= pend_rssi_nxt;
    status_r    <= status_nxt;
    peer_r      <= peer_nxt;
    plen_r      <= plen_nxt;
    lseq_r      <= lseq_nxt;
    rssi_r      <= rssi_nxt;
    rx_r        <= rx_nxt;
    lost_r      <= lost_nxt;
    seen_r      <= seen_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    clr_report_nxt = clr_report_r;
    rx_on_nxt      = rx_on_r;
    pend_func_nxt  = pend_func_r;
    pend_peer_nxt  = pend_peer_r;
    pend_seq_nxt   = pend_seq_r;
    pend_plen_nxt  = pend_plen_r;
    pend_rssi_nxt  = pend_rssi_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    peer_nxt       = peer_r;
    plen_nxt       = plen_r;
    lseq_nxt       = lseq_r;
    rssi_nxt       = rssi_r;
    rx_nxt         = rx_r;
    lost_nxt       = lost_r;
    seen_nxt       = seen_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt      = S_IDLE;
          clr_idx_nxt    = '0;
          clr_report_nxt = 1'b0;
          if (clr_report_r) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_CLEARED;
            peer_nxt      = 16'd0;
            plen_nxt      = 8'd0;
            lseq_nxt      = 32'd0;
            rssi_nxt      = 8'd0;
            rx_nxt        = 32'd0;
            lost_nxt      = 32'd0;
            seen_nxt      = 1'b0;
          end
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          pend_func_nxt = func_in;
          pend_peer_nxt = in_peer_id;
          pend_seq_nxt  = in_seq_num;
          pend_plen_nxt = plen_in;
          pend_rssi_nxt = in_signal_byte;
          // defaults for the transactions answered at once
          status_nxt    = ST_STOPPED;
          peer_nxt      = in_peer_id;
          plen_nxt      = 8'd0;
          lseq_nxt      = 32'd0;
          rssi_nxt      = 8'd0;
          rx_nxt        = 32'd0;
          lost_nxt      = 32'd0;
          seen_nxt      = 1'b0;
          if (func_in == FN_CLEAR) begin
            rx_on_nxt      = 1'b1;
            clr_report_nxt = 1'b1;
            clr_idx_nxt    = '0;
            state_nxt      = S_CLEAR;
          end else if (func_in == FN_STOP) begin
            rx_on_nxt     = 1'b0;
            out_valid_nxt = 1'b1;
            status_nxt    = ST_STOPPED;
            peer_nxt      = 16'd0;
          end else if (func_in == FN_PACKET && !rx_on_r) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_OFF;
          end else if (!peer_ok) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_BAD_PEER;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt     = S_IDLE;
        mem_we        = (pend_func_r == FN_PACKET);
        mem_waddr     = pend_peer_r[AW-1:0];
        mem_wdata     = upd_entry;
        out_valid_nxt = 1'b1;
        status_nxt    = (pend_func_r == FN_PACKET) ? ST_ACCEPTED : ST_READ;
        peer_nxt      = pend_peer_r;
        plen_nxt      = (pend_func_r == FN_PACKET) ? pend_plen_r : 8'd0;
        rssi_nxt      = (pend_func_r == FN_PACKET) ? pend_rssi_r : 8'd0;
        lseq_nxt      = view.last_seq;
        rx_nxt        = view.rx_cnt;
        lost_nxt      = view.lost_cnt;
        seen_nxt      = view.seen;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_peer_out       = peer_r;
  assign out_payload_length = plen_r;
  assign out_last_seq       = lseq_r;
  assign out_rssi           = rssi_r;
  assign out_received_count = rx_r;
  assign out_lost_count     = lost_r;
  assign out_peer_seen      = seen_r;

  // table writes only come from the sweep or a packet write-back
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || (state_r == S_RD && pend_func_r == FN_PACKET)))
    else $error("table written outside sweep or write-back");

  // every read or packet table access gives a result in the following cycle
  a_rd_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> out_valid && !busy)
    else $error("no result after table access");

  // the end of a commanded sweep reports a clear
  a_clear_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_idx_r == LAST_IDX && clr_report_r)
      |=> (out_valid && out_status == ST_CLEARED && rx_on_r))
    else $error("clear sweep ended without report");

  // an accepted packet always reports its peer as seen
  a_packet_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ACCEPTED) |-> out_peer_seen)
    else $error("accepted packet with peer not seen");

endmodule

`default_nettype wire

// ===== tb/per_peer_packet_loss_counter_tb.sv =====
// Testbench for per_peer_packet_loss_counter: directed and random command streams, with each
// result checked against a behavioural model of the peer table, held inside this file.
// Depends on plpc_pkg and the per_peer_packet_loss_counter RTL.
`timescale 1ns / 1ps

module per_peer_packet_loss_counter_tb;
  import plpc_pkg::*;

  localparam int PEERS = PEERS_DEFAULT;

  typedef struct {
    func_t       func;
    logic [15:0] peer;
    logic [31:0] seq;
    logic [7:0]  flen;
    logic [7:0]  sig;
  } peer_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] peer;
    logic [7:0]  payload_len;
    logic [31:0] last_seq;
    logic [7:0]  rssi;
    logic [31:0] rx_cnt;
    logic [31:0] lost_cnt;
    logic        seen;
  } loss_report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [15:0] in_peer_id = '0;
  logic [31:0] in_seq_num = '0;
  logic [7:0]  in_frame_length = '0;
  logic [7:0]  in_signal_byte = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_peer_out;
  logic [7:0]  out_payload_length;
  logic [31:0] out_last_seq;
  logic [7:0]  out_rssi;
  logic [31:0] out_received_count;
  logic [31:0] out_lost_count;
  logic        out_peer_seen;

  // Shadow of the peer table
  logic        peer_seen_q [PEERS];
  logic        seq_written [PEERS];
  logic [31:0] peer_last_seq [PEERS];
  logic [31:0] peer_rx_cnt [PEERS];
  logic [31:0] peer_lost_cnt [PEERS];
  logic        rx_enabled;

  loss_report_t pending_reports[$];
  int          fail_count = 0;
  int          sender_idle_pct = 0;

  per_peer_packet_loss_counter #(.MAX_PEERS(PEERS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_peer_id(in_peer_id), .in_seq_num(in_seq_num),
    .in_frame_length(in_frame_length), .in_signal_byte(in_signal_byte),
    .out_valid(out_valid), .out_status(out_status), .out_peer_out(out_peer_out),
    .out_payload_length(out_payload_length), .out_last_seq(out_last_seq),
    .out_rssi(out_rssi), .out_received_count(out_received_count),
    .out_lost_count(out_lost_count), .out_peer_seen(out_peer_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fill_peer_fields(inout loss_report_t r, input int p);
    r.last_seq = peer_seen_q[p] ? peer_last_seq[p] : 32'd0;
    r.rx_cnt   = peer_rx_cnt[p];
    r.lost_cnt = peer_lost_cnt[p];
    r.seen     = peer_seen_q[p];
  endfunction

  // Applies one command to the shadow table and returns the report it should produce
  function automatic loss_report_t predict_loss_report(input peer_cmd_t c);
    loss_report_t r;
    logic [31:0]  next_seq;
    int           p;
    r = '0;
    p = c.peer;
    case (c.func)
      FN_CLEAR: begin
        for (int i = 0; i < PEERS; i++) begin
          peer_seen_q[i] = 1'b0;
          peer_rx_cnt[i] = '0;
          peer_lost_cnt[i] = '0;
        end
        rx_enabled = 1'b1;
        r.status = ST_CLEARED;
      end
      FN_STOP: begin
        rx_enabled = 1'b0;
        r.status = ST_STOPPED;
      end
      default: begin
        r.peer = c.peer;
        if (c.func == FN_PACKET && !rx_enabled) begin
          r.status = ST_OFF;
        end else if (p >= PEERS) begin
          r.status = ST_BAD_PEER;
        end else if (c.func == FN_READ) begin
          r.status = ST_READ;
          fill_peer_fields(r, p);
        end else begin
          peer_rx_cnt[p] = peer_rx_cnt[p] + 32'd1;
          if (peer_seen_q[p]) begin
            next_seq = peer_last_seq[p] + 32'd1;
            if (next_seq != c.seq) peer_lost_cnt[p] = peer_lost_cnt[p] + (c.seq - next_seq);
          end
          peer_seen_q[p] = 1'b1;
          seq_written[p] = 1'b1;
          peer_last_seq[p] = c.seq;
          r.status = ST_ACCEPTED;
          r.payload_len = (c.flen >= TRAILER_BYTES) ? c.flen - TRAILER_BYTES : 8'd0;
          r.rssi = c.sig;
          fill_peer_fields(r, p);
        end
      end
    endcase
    return r;
  endfunction

  // Holds start high until the transaction is taken; start is left high for a following one
  task automatic send_cmd(input peer_cmd_t c);
    in_func         <= c.func;
    in_peer_id      <= c.peer;
    in_seq_num      <= c.seq;
    in_frame_length <= c.flen;
    in_signal_byte  <= c.sig;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_reports.push_back(predict_loss_report(c));
  endtask

  task automatic send(input func_t f, input logic [15:0] p, input logic [31:0] s,
                      input logic [7:0] fl, input logic [7:0] sg);
    peer_cmd_t c;
    c.func = f;
    c.peer = p;
    c.seq  = s;
    c.flen = fl;
    c.sig  = sg;
    send_cmd(c);
  endtask

  task automatic sender_pause();
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    loss_report_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result with no transaction outstanding (status %0d)", out_status);
        fail_count++;
      end else begin
        e = pending_reports.pop_front();
        check_field("status", e.status, out_status);
        check_field("peer_out", e.peer, out_peer_out);
        check_field("payload_length", e.payload_len, out_payload_length);
        check_field("last_seq", e.last_seq, out_last_seq);
        check_field("rssi", e.rssi, out_rssi);
        check_field("received_count", e.rx_cnt, out_received_count);
        check_field("lost_count", e.lost_cnt, out_lost_count);
        check_field("peer_seen", e.seen, out_peer_seen);
      end
    end
  end

  task automatic test_reception_off();
    send(FN_PACKET, 16'd3, 32'h1234_5678, 8'd10, 8'd20);
    send(FN_READ, 16'd16, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send(FN_READ, 16'hFFFF, 32'd0, 8'd0, 8'd0);
    send(FN_STOP, 16'd5, 32'd7, 8'd9, 8'd1);
  endtask

  task automatic test_sequence_tracking();
    send(FN_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send(FN_PACKET, 16'd0, 32'hFFFF_FFFF, 8'd0, 8'd0);
    send(FN_PACKET, 16'd0, 32'd0, 8'd1, 8'hFF);        // wraps, no loss
    send(FN_PACKET, 16'd0, 32'd5, 8'd2, 8'h55);        // gap of four
    send(FN_PACKET, 16'd0, 32'd3, 8'hFF, 8'hAA);       // goes backwards
    send(FN_PACKET, 16'd15, 32'h8000_0000, 8'd3, 8'h01);
    send(FN_PACKET, 16'd15, 32'h8000_0000, 8'd4, 8'h80); // repeated sequence
    send(FN_PACKET, 16'd7, 32'hA5A5_5A5A, 8'hFE, 8'h7F);
  endtask

  task automatic test_bad_peer();
    send(FN_PACKET, 16'd16, 32'd1, 8'd40, 8'd2);
    send(FN_PACKET, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send(FN_READ, 16'h8000, 32'd0, 8'd0, 8'd0);
  endtask

  task automatic test_read_stop_clear();
    send(FN_READ, 16'd0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send(FN_READ, 16'd15, 32'd0, 8'd0, 8'd0);
    send(FN_STOP, 16'd0, 32'd0, 8'd0, 8'd0);
    send(FN_PACKET, 16'd0, 32'd4, 8'd12, 8'd3);
    send(FN_READ, 16'd0, 32'd0, 8'd0, 8'd0);
    send(FN_CLEAR, 16'd0, 32'd0, 8'd0, 8'd0);
    send(FN_READ, 16'd0, 32'd0, 8'd0, 8'd0);           // cleared: not seen
    send(FN_PACKET, 16'd0, 32'd100, 8'd6, 8'd9);
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct);
    peer_cmd_t c;
    int        pick;
    int        p;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < n; k++) begin
      pick   = $urandom_range(99);
      c.peer = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(PEERS - 1));
      c.seq  = $urandom();
      c.flen = ($urandom_range(9) == 0) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
      c.sig  = 8'($urandom_range(255));
      p = c.peer;
      if (!rx_enabled && pick < 25) c.func = FN_CLEAR;
      else if (pick < 2) c.func = FN_CLEAR;
      else if (pick < 4) c.func = FN_STOP;
      else if (pick < 16) c.func = FN_READ;
      else c.func = FN_PACKET;
      // never read back a sequence slot that has not been written since reset
      if (c.func == FN_READ && p < PEERS && !seq_written[p]) c.peer = 16'(PEERS + p);
      // mostly in-order streams per peer, with gaps, repeats and jumps mixed in
      if (c.func == FN_PACKET && p < PEERS && peer_seen_q[p]) begin
        pick = $urandom_range(99);
        if (pick < 70) c.seq = peer_last_seq[p] + 32'd1;
        else if (pick < 85) c.seq = peer_last_seq[p] + 32'd1 + 32'($urandom_range(1, 20));
        else if (pick < 92) c.seq = peer_last_seq[p];
      end
      sender_pause();
      send_cmd(c);
    end
  endtask

  initial begin
    int waited;
    waited = 0;
    for (int i = 0; i < PEERS; i++) begin
      peer_seen_q[i] = 1'b0;
      seq_written[i] = 1'b0;
      peer_last_seq[i] = '0;
      peer_rx_cnt[i] = '0;
      peer_lost_cnt[i] = '0;
    end
    rx_enabled = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reception_off();
    test_sequence_tracking();
    test_bad_peer();
    test_read_stop_clear();
    test_random_traffic(170, 12);
    test_random_traffic(170, 81);
    test_random_traffic(170, 0);

    start <= 1'b0;
    while (pending_reports.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("per_peer_packet_loss_counter_tb OK");
    end else begin
      $display("per_peer_packet_loss_counter_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("per_peer_packet_loss_counter_tb NOT OK");
    $finish;
  end

endmodule
